// ----- sv/chr_pkg.sv -----
// ----------------------------------------------------------------------------
// chr_pkg
// Shared types and constants for the consistent hash ring lookup block.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int HND_W        = 16;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_REG        = 2'd0,
    MODE_SELECT     = 2'd1,
    MODE_DEL_KEY    = 2'd2,
    MODE_DEL_HANDLE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // one ring point as held in the table
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] hnd;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // verdict of the evaluate unit on one table entry
  typedef struct packed {
    logic key_eq;
    logic hnd_eq;
    logic free;
    logic take_min;
    logic take_up;
  } cmp_flags_t;

endpackage

// ----- sv/chr_mem.sv -----
// ----------------------------------------------------------------------------
// chr_mem
// Point table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chr_mem #(
  parameter int DEPTH = chr_pkg::CAPACITY_DEF,
  parameter int AW    = 6,
  parameter int WIDTH = chr_pkg::ENTRY_W
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/chr_cmp.sv -----
// ----------------------------------------------------------------------------
// chr_cmp
// Evaluate unit: compares one table entry against the query and the running
// minimum and successor candidates.
// ----------------------------------------------------------------------------
module chr_cmp (
  input  chr_pkg::entry_t                q_entry,
  input  logic [chr_pkg::KEY_W-1:0]      q_key,
  input  logic [chr_pkg::HND_W-1:0]      q_hnd,
  input  logic                           have_min,
  input  logic [chr_pkg::KEY_W-1:0]      min_key,
  input  logic                           have_up,
  input  logic [chr_pkg::KEY_W-1:0]      up_key,
  output chr_pkg::cmp_flags_t            flags
);

  import chr_pkg::*;

  always_comb begin
    flags.key_eq   = q_entry.vld && (q_entry.key == q_key);
    flags.hnd_eq   = q_entry.vld && (q_entry.hnd == q_hnd);
    flags.free     = !q_entry.vld;
    flags.take_min = q_entry.vld && (!have_min || (q_entry.key < min_key));
    // successor: strictly above the query, below the best so far
    flags.take_up  = q_entry.vld && (q_entry.key > q_key) &&
                     (!have_up || (q_entry.key < up_key));
  end

endmodule

// ----- sv/consistent_hash_ring.sv -----
// ----------------------------------------------------------------------------
// consistent_hash_ring
// Ring of up to CAPACITY points (key, handle) with register, select,
// delete-by-key and delete-by-handle, served by a table scan.
// ----------------------------------------------------------------------------
//  channel  handshake             fields
//  req      req_valid/req_stall   mode, key, handle
//  rsp      rsp_valid/rsp_stall   status, selected_handle
//
//  Each word passes from accept to the next accept through: the accept, one
//  table read per entry through the single read port and evaluate unit,
//  the registered read data, a write-back and the result load. req_stall
//  stays high from the accept until the result is in the output register.
//  After reset a clearing pass marks every entry free; req_stall stays high
//  until it ends.
//  A new word is taken while a result waits in the output register; the
//  next result holds in the block until rsp_stall drops.
// ----------------------------------------------------------------------------
module consistent_hash_ring #(
  parameter int CAPACITY = chr_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [chr_pkg::MODE_W-1:0]    mode,
  input  logic [chr_pkg::KEY_W-1:0]     key,
  input  logic [chr_pkg::HND_W-1:0]     handle,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [chr_pkg::STATUS_W-1:0]  status,
  output logic [chr_pkg::HND_W-1:0]     selected_handle
);

  import chr_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t           state, state_next;
  logic [CW-1:0]    cnt;
  logic             rd_vld;
  logic [AW-1:0]    rd_idx;
  logic             issue;
  logic             accept;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  entry_t           rd_data;
  logic             load_out;
  logic             del_hit;

  mode_t            q_mode;
  logic [KEY_W-1:0] q_key;
  logic [HND_W-1:0] q_hnd;

  logic             have_min, have_up, have_match, have_free;
  logic [KEY_W-1:0] min_key, up_key;
  logic [HND_W-1:0] min_hnd, up_hnd;
  logic [AW-1:0]    match_idx, free_idx;
  cmp_flags_t       flags;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  chr_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  chr_cmp u_cmp (
    .q_entry  (rd_data),
    .q_key    (q_key),
    .q_hnd    (q_hnd),
    .have_min (have_min),
    .min_key  (min_key),
    .have_up  (have_up),
    .up_key   (up_key),
    .flags    (flags)
  );

  assign del_hit = rd_vld &&
                   (((q_mode == MODE_DEL_KEY) && flags.key_eq) ||
                    ((q_mode == MODE_DEL_HANDLE) && flags.hnd_eq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    load_out   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt[AW-1:0];
        if (cnt == CW'(CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = (cnt < CW'(CAPACITY));
        // deletes retire inline; the slot was already read
        if (del_hit) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx;
          wr_data = '{vld: 1'b0, key: rd_data.key, hnd: rd_data.hnd};
        end
        if (!issue && !rd_vld) begin
          state_next = S_DONE;
          if ((q_mode == MODE_REG) && (have_match || have_free)) begin
            wr_en   = 1'b1;
            wr_addr = have_match ? match_idx : free_idx;
            wr_data = '{vld: 1'b1, key: q_key, hnd: q_hnd};
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (state == S_CLEAR) begin
        cnt <= (state_next == S_IDLE) ? '0 : cnt + 1'b1;
      end else if (accept) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[AW-1:0];
    if (accept) begin
      q_mode     <= mode_t'(mode);
      q_key      <= key;
      q_hnd      <= handle;
      have_min   <= 1'b0;
      have_up    <= 1'b0;
      have_match <= 1'b0;
      have_free  <= 1'b0;
    end else if (rd_vld) begin
      if (flags.take_min) begin
        have_min <= 1'b1;
        min_key  <= rd_data.key;
        min_hnd  <= rd_data.hnd;
      end
      if (flags.take_up) begin
        have_up <= 1'b1;
        up_key  <= rd_data.key;
        up_hnd  <= rd_data.hnd;
      end
      if (flags.key_eq && !have_match) begin
        have_match <= 1'b1;
        match_idx  <= rd_idx;
      end
      // keep the lowest free slot
      if (flags.free && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= rd_idx;
      end
    end
    if (load_out) begin
      status          <= ST_OK;
      selected_handle <= '0;
      priority case (q_mode)
        MODE_REG: begin
          if (!have_match && !have_free) begin
            status <= ST_FULL;
          end
        end
        MODE_SELECT: begin
          priority if (have_up) begin
            selected_handle <= up_hnd;
          end else if (have_min) begin
            selected_handle <= min_hnd;
          end else begin
            status <= ST_EMPTY;
          end
        end
        default: begin
          status <= ST_OK;
        end
      endcase
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the consistent hash ring lookup block against its own model of the
// ring. The model is kept in a scoreboard class: the class works out each
// expected result as a word is taken and compares the results in order. The
// test starts with a short list of words aimed at the corner cases, then
// runs random phases that grow, churn and shrink the ring. The sender works
// in bursts and the receiver stalls to a changing pattern.
// ----------------------------------------------------------------------------

class ring_scoreboard;

  logic [chr_pkg::KEY_W-1:0] pt_key [chr_pkg::CAPACITY_DEF];
  logic [chr_pkg::HND_W-1:0] pt_hnd [chr_pkg::CAPACITY_DEF];
  bit                        pt_used[chr_pkg::CAPACITY_DEF];

  chr_pkg::status_t          want_status[$];
  logic [chr_pkg::HND_W-1:0] want_handle[$];

  int errors;
  int words;
  int results;
  int n_full;
  int n_wrap;
  int n_empty;
  int peak_fill;

  function new();
    pt_used = '{default: 1'b0};
  endfunction

  function int pending();
    return want_status.size();
  endfunction

  task report_mismatch(string msg);
    $display("mismatch at result %0d: %s", results, msg);
    errors++;
  endtask

  // Apply one accepted word to the ring and queue the result it must give.
  function void note_word(chr_pkg::mode_t m, logic [chr_pkg::KEY_W-1:0] k,
                          logic [chr_pkg::HND_W-1:0] h);
    int hit;
    int open;
    int fill;
    bit have_up;
    bit have_min;
    logic [chr_pkg::KEY_W-1:0] up_k;
    logic [chr_pkg::KEY_W-1:0] min_k;
    logic [chr_pkg::HND_W-1:0] up_h;
    logic [chr_pkg::HND_W-1:0] min_h;
    chr_pkg::status_t st;
    logic [chr_pkg::HND_W-1:0] sel;

    hit = -1;
    open = -1;
    fill = 0;
    have_up = 1'b0;
    have_min = 1'b0;
    up_k = '0;
    min_k = '0;
    up_h = '0;
    min_h = '0;
    st = chr_pkg::ST_OK;
    sel = '0;
    words++;

    for (int i = 0; i < chr_pkg::CAPACITY_DEF; i++) begin
      if (pt_used[i] && pt_key[i] == k && hit < 0) hit = i;
      if (!pt_used[i] && open < 0) open = i;
    end

    case (m)
      chr_pkg::MODE_REG: begin
        if (hit >= 0) begin
          pt_hnd[hit] = h;
        end else if (open >= 0) begin
          pt_used[open] = 1'b1;
          pt_key[open] = k;
          pt_hnd[open] = h;
        end else begin
          st = chr_pkg::ST_FULL;
          n_full++;
        end
      end
      chr_pkg::MODE_SELECT: begin
        for (int i = 0; i < chr_pkg::CAPACITY_DEF; i++) begin
          if (pt_used[i]) begin
            if (!have_min || pt_key[i] < min_k) begin
              have_min = 1'b1;
              min_k = pt_key[i];
              min_h = pt_hnd[i];
            end
            if (pt_key[i] > k && (!have_up || pt_key[i] < up_k)) begin
              have_up = 1'b1;
              up_k = pt_key[i];
              up_h = pt_hnd[i];
            end
          end
        end
        if (have_up) begin
          sel = up_h;
        end else if (have_min) begin
          // nothing above the query: wrap to the lowest point
          sel = min_h;
          n_wrap++;
        end else begin
          st = chr_pkg::ST_EMPTY;
          n_empty++;
        end
      end
      chr_pkg::MODE_DEL_KEY: begin
        if (hit >= 0) pt_used[hit] = 1'b0;
      end
      default: begin
        for (int i = 0; i < chr_pkg::CAPACITY_DEF; i++)
          if (pt_used[i] && pt_hnd[i] == h) pt_used[i] = 1'b0;
      end
    endcase

    for (int i = 0; i < chr_pkg::CAPACITY_DEF; i++) if (pt_used[i]) fill++;
    if (fill > peak_fill) peak_fill = fill;

    want_status.push_back(st);
    want_handle.push_back(sel);
  endfunction

  task check_result(logic [chr_pkg::STATUS_W-1:0] got_st,
                    logic [chr_pkg::HND_W-1:0] got_h);
    chr_pkg::status_t exp_st;
    logic [chr_pkg::HND_W-1:0] exp_h;

    if (want_status.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d handle %h",
                                got_st, got_h));
    end else begin
      exp_st = want_status.pop_front();
      exp_h = want_handle.pop_front();
      if (got_st !== exp_st)
        report_mismatch($sformatf("status %0d, want %0d", got_st, exp_st));
      if (got_h !== exp_h)
        report_mismatch($sformatf("selected_handle %h, want %h", got_h, exp_h));
      results++;
    end
  endtask

endclass

module testbench;
  import chr_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = CAPACITY_DEF + 16;
  localparam int POOL_SIZE      = 56;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_WORDS    = 53;

  typedef enum {PH_GROW, PH_CHURN, PH_SHRINK} phase_t;
  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [MODE_W-1:0]   mode = '0;
  logic [KEY_W-1:0]    key = '0;
  logic [HND_W-1:0]    handle = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [HND_W-1:0]    selected_handle;

  ring_scoreboard sb;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  int quiet_cycles = 0;

  consistent_hash_ring dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .mode            (mode),
    .key             (key),
    .handle          (handle),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .selected_handle (selected_handle)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watch both channels; feed the scoreboard and guard against a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_stall === 1'b0) begin
        sb.note_word(mode_t'(mode), key, handle);
        quiet_cycles = 0;
      end else if (rsp_valid === 1'b1 && !rsp_stall) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(status, selected_handle);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns, holding each one for a random stretch.
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 400);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  rsp_stall <= 1'b0;
      RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
      default:  rsp_stall <= ((rx_tick % 7) < 4);
    endcase
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_word(mode_t m, logic [KEY_W-1:0] k, logic [HND_W-1:0] h);
    req_valid <= 1'b1;
    mode <= m;
    key <= k;
    handle <= h;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task pause_sender(int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Hold the sender until every outstanding result is back.
  task wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      5: k = key_pool[$urandom_range(0, POOL_SIZE - 1)] +
             ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
      6: begin
        case ($urandom_range(0, 3))
          0:       k = '0;
          1:       k = '1;
          2:       k = 32'h8000_0000;
          default: k = 32'h7FFF_FFFF;
        endcase
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  // Half the time one of nine shared handles (0 to 7 or FFFF), so delete-by-handle drops several points.
  function automatic logic [HND_W-1:0] pick_handle();
    logic [HND_W-1:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: h = HND_W'($urandom_range(0, 7));
      4:          h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    h = HND_W'($urandom_range(0, 65535));
    endcase
    return h;
  endfunction

  function automatic mode_t pick_mode(phase_t ph);
    int r;
    mode_t m;
    r = $urandom_range(0, 99);
    case (ph)
      PH_GROW:  m = (r < 85) ? MODE_REG : (r < 95) ? MODE_SELECT :
                    (r < 98) ? MODE_DEL_KEY : MODE_DEL_HANDLE;
      PH_CHURN: m = mode_t'(r % 4);
      default:  m = (r < 15) ? MODE_REG : (r < 40) ? MODE_SELECT :
                    (r < 75) ? MODE_DEL_KEY : MODE_DEL_HANDLE;
    endcase
    return m;
  endfunction

  initial begin
    phase_t plan[PHASE_COUNT];
    int burst_left;

    plan = '{PH_GROW, PH_GROW, PH_CHURN, PH_SHRINK, PH_GROW,
             PH_GROW, PH_CHURN, PH_SHRINK, PH_SHRINK, PH_CHURN};
    burst_left = $urandom_range(1, 20);
    sb = new();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner cases on an empty and then a small ring
    send_word(MODE_SELECT, 32'h0000_0000, 16'h0000);
    send_word(MODE_DEL_KEY, 32'h0000_0005, 16'h0000);
    send_word(MODE_DEL_HANDLE, 32'h0000_0000, 16'h0000);
    send_word(MODE_REG, 32'h0000_0000, 16'h0000);
    send_word(MODE_REG, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_REG, 32'h8000_0000, 16'h1234);
    send_word(MODE_SELECT, 32'h0000_0000, 16'hFFFF);
    send_word(MODE_SELECT, 32'h7FFF_FFFF, 16'h0000);
    send_word(MODE_SELECT, 32'h8000_0000, 16'h0000);
    send_word(MODE_SELECT, 32'hFFFF_FFFF, 16'h0000);
    send_word(MODE_REG, 32'h8000_0000, 16'hABCD);
    send_word(MODE_SELECT, 32'h0000_0000, 16'h0000);
    send_word(MODE_REG, 32'h0000_0010, 16'hABCD);
    send_word(MODE_DEL_HANDLE, 32'hFFFF_FFFF, 16'hABCD);
    send_word(MODE_SELECT, 32'h0000_0000, 16'h0000);
    send_word(MODE_DEL_KEY, 32'h1234_5678, 16'h0000);
    send_word(MODE_DEL_HANDLE, 32'h0000_0000, 16'h5555);
    send_word(MODE_DEL_KEY, 32'hFFFF_FFFF, 16'h0000);
    send_word(MODE_SELECT, 32'hFFFF_FFFF, 16'h0000);
    send_word(MODE_DEL_KEY, 32'h0000_0000, 16'hFFFF);
    send_word(MODE_SELECT, 32'h0000_0000, 16'h0000);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(pick_mode(plan[p]), pick_key(), pick_handle());
        burst_left--;
        if (burst_left <= 0) begin
          pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                    : $urandom_range(1, 10));
          burst_left = $urandom_range(1, 20);
        end
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words and %0d results; ring peaked at %0d of %0d points",
             sb.words, sb.results, sb.peak_fill, CAPACITY_DEF);
    $display("saw %0d full rejects, %0d wrapped selects, %0d empty selects",
             sb.n_full, sb.n_wrap, sb.n_empty);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
